@@ design/ppo_pkg.sv @@
`default_nettype none
package ppo_pkg;

  // Field widths
  localparam int unsigned SampleW = 8;
  localparam int unsigned DvdW    = 16;  // dividend of the long divide
  localparam int unsigned DsrW    = 9;   // divisor, up to 256
  localparam int unsigned RemW    = 10;  // partial remainder
  localparam int unsigned StepsA  = 16;  // cells of the first divide
  localparam int unsigned StepsB  = 8;   // cells of the second divide
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOW    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HIGH   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_LEVELS = 2'd3;

  typedef enum logic [1:0] {
    MODE_INVERT  = 2'd0,
    MODE_STRETCH = 2'd1,
    MODE_POSTER  = 2'd2,
    MODE_PASS    = 2'd3
  } mode_e;

  // Per-item data that rides along the divider chain
  typedef struct packed {
    logic [SampleW-1:0] sample;
    mode_e              mode;
    logic               eq;     // stretch bounds equal
    logic               thr;    // threshold result when bounds equal
    logic               sdiff;  // numerator and divisor signs differ
    logic               sat;    // stretch quotient above 255
    logic [SampleW-1:0] qa;     // stretch quotient, low byte
    logic [DsrW-1:0]    step;   // posterize step
  } side_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DvdW-1:0] dvd;
    logic [DvdW-1:0] quo;
    logic [DsrW-1:0] dsr;
    side_t           side;
  } div_t;

endpackage
`default_nettype wire

@@ design/ppo_div_cell.sv @@
`default_nettype none
module ppo_div_cell
  import ppo_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic vld_i,
  input  wire div_t d_i,
  output logic      vld_o,
  output div_t      q_o
);

  logic            vld_q;
  div_t            data_q, data_d;
  logic [RemW-1:0] rem_sh;
  logic            ge;

  // One restoring step: shift in a dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {d_i.rem[RemW-2:0], d_i.dvd[DvdW-1]};
    ge     = (rem_sh >= {1'b0, d_i.dsr});
    data_d = d_i;
    data_d.rem = ge ? (rem_sh - {1'b0, d_i.dsr}) : rem_sh;
    data_d.dvd = {d_i.dvd[DvdW-2:0], 1'b0};
    data_d.quo = {d_i.quo[DvdW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = data_q;

endmodule
`default_nettype wire

@@ design/ppo_front.sv @@
`default_nettype none
module ppo_front
  import ppo_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire logic [SampleW-1:0] sample_i,
  input  wire mode_e              mode_i,
  input  wire logic [SampleW-1:0] low_i,
  input  wire logic [SampleW-1:0] high_i,
  input  wire logic [SampleW-1:0] levels_i,
  output logic                    vld_o,
  output div_t                    q_o
);

  logic               vld_q;
  div_t               data_q, data_d;
  logic [SampleW-1:0] ds, dd;
  logic               nneg, dneg;
  logic [DvdW-1:0]    num;
  logic [DsrW-1:0]    lvl;

  // Magnitudes and signs of (s - low) * 255 and (high - low)
  always_comb begin
    nneg = (sample_i < low_i);
    dneg = (high_i < low_i);
    ds   = nneg ? (low_i - sample_i) : (sample_i - low_i);
    dd   = dneg ? (low_i - high_i) : (high_i - low_i);
    num  = {ds, 8'h00} - {8'h00, ds};
    lvl  = (levels_i == '0) ? DsrW'(1) : {1'b0, levels_i};

    data_d             = '0;
    data_d.side.sample = sample_i;
    data_d.side.mode   = mode_i;
    data_d.side.eq     = (low_i == high_i);
    data_d.side.thr    = (sample_i > low_i);
    data_d.side.sdiff  = nneg ^ dneg;
    // Posterize first finds the step as 256 / levels
    if (mode_i == MODE_POSTER) begin
      data_d.dvd = DvdW'(256);
      data_d.dsr = lvl;
    end else begin
      data_d.dvd = num;
      data_d.dsr = {1'b0, dd};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = data_q;

endmodule
`default_nettype wire

@@ design/ppo_handoff.sv @@
`default_nettype none
module ppo_handoff
  import ppo_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic vld_i,
  input  wire div_t d_i,
  output logic      vld_o,
  output div_t      q_o
);

  logic vld_q;
  div_t data_q, data_d;

  // Keep the first quotient, then set up sample / step
  always_comb begin
    data_d           = '0;
    data_d.side      = d_i.side;
    data_d.side.sat  = |d_i.quo[DvdW-1:SampleW];
    data_d.side.qa   = d_i.quo[SampleW-1:0];
    data_d.side.step = d_i.quo[DsrW-1:0];
    data_d.dvd       = {d_i.side.sample, {(DvdW-SampleW){1'b0}}};
    data_d.dsr       = d_i.quo[DsrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = data_q;

endmodule
`default_nettype wire

@@ design/ppo_back.sv @@
`default_nettype none
module ppo_back
  import ppo_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire div_t               d_i,
  output logic                    vld_o,
  output logic [SampleW-1:0]      sample_o
);

  logic               vld_q;
  logic [SampleW-1:0] res_q, res_d;
  logic [9:0]         post_v;
  logic [SampleW-1:0] s;

  // Final mapping per mode; posterize uses s - s mod step + step / 2
  always_comb begin
    s      = d_i.side.sample;
    post_v = {2'b00, s} - {1'b0, d_i.rem[DsrW-1:0]} + {2'b00, d_i.side.step[DsrW-1:1]};
    case (d_i.side.mode)
      MODE_INVERT: begin
        res_d = 8'd255 - s;
      end
      MODE_STRETCH: begin
        if (d_i.side.eq) begin
          res_d = d_i.side.thr ? 8'd255 : 8'd0;
        end else if (d_i.side.sdiff) begin
          res_d = 8'd0;
        end else if (d_i.side.sat) begin
          res_d = 8'd255;
        end else begin
          res_d = d_i.side.qa;
        end
      end
      MODE_POSTER: begin
        res_d = (post_v > 10'd255) ? 8'd255 : post_v[SampleW-1:0];
      end
      default: begin
        res_d = s;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign vld_o    = vld_q;
  assign sample_o = res_q;

endmodule
`default_nettype wire

@@ design/pixel_point_operation.sv @@
// Pixel point operation: maps one 8-bit sample per item (invert, contrast
// stretch, posterize, or pass-through for mode code 3).
// Input channel: in_valid_i / in_stall_o with sample_in_i. Output channel:
// out_valid_o / out_stall_i with sample_out_o. Both accept on valid & !stall.
// Configuration: write cfg_data_i to register cfg_index_i (0 mode, 1 low
// bound, 2 high bound, 3 level count) while cfg_we_i is high; only while
// no items are in flight.
// Throughput: one item per cycle while the output is not stalled.
// Pipeline: 27 register stages (front stage, 16 divider cells, handoff
// stage, 8 divider cells, output register); out_valid_o rises when the item
// reaches the output register and stays high while out_stall_i holds it.
// The chain of restoring-divide cells, one quotient bit per cell, sets the
// latency; every cell advances together.
// Stall: while out_valid_o is high and out_stall_i is high the whole chain
// holds; one further item is taken into a skid register, then in_stall_o
// stays high until that item enters the front stage when the chain moves.
// Reset: clears all valid bits and the skid; registers return to mode
// invert, low 0, high 255, level count 4.
`default_nettype none
module pixel_point_operation
  import ppo_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [SampleW-1:0] sample_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [SampleW-1:0]      sample_out_o
);

  localparam int unsigned NumCells = StepsA + StepsB;

  mode_e              mode_q;
  logic [SampleW-1:0] low_q, high_q, levels_q;
  logic               skid_vld_q, skid_vld_d;
  logic [SampleW-1:0] skid_q;
  logic               en, acc;
  logic               front_vld;
  logic [SampleW-1:0] front_sample;
  logic               cell_vld [NumCells+2];
  div_t               cell_dat [NumCells+2];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_INVERT;
      low_q    <= 8'd0;
      high_q   <= 8'd255;
      levels_q <= 8'd4;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:   mode_q   <= mode_e'(cfg_data_i[1:0]);
        CFG_LOW:    low_q    <= cfg_data_i;
        CFG_HIGH:   high_q   <= cfg_data_i;
        CFG_LEVELS: levels_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Chain advance and input skid
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = skid_vld_q;
  assign acc        = in_valid_i && !skid_vld_q;

  always_comb begin
    skid_vld_d = skid_vld_q;
    if (en) begin
      skid_vld_d = 1'b0;
    end else if (acc) begin
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && acc) begin
      skid_q <= sample_in_i;
    end
  end

  assign front_vld    = skid_vld_q || in_valid_i;
  assign front_sample = skid_vld_q ? skid_q : sample_in_i;

  ppo_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (front_vld),
    .sample_i (front_sample),
    .mode_i   (mode_q),
    .low_i    (low_q),
    .high_i   (high_q),
    .levels_i (levels_q),
    .vld_o    (cell_vld[0]),
    .q_o      (cell_dat[0])
  );

  // First divide: stretch quotient or posterize step
  for (genvar i = 0; i < StepsA; i++) begin : g_div_a
    ppo_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (cell_vld[i]),
      .d_i    (cell_dat[i]),
      .vld_o  (cell_vld[i+1]),
      .q_o    (cell_dat[i+1])
    );
  end

  ppo_handoff u_handoff (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (cell_vld[StepsA]),
    .d_i    (cell_dat[StepsA]),
    .vld_o  (cell_vld[StepsA+1]),
    .q_o    (cell_dat[StepsA+1])
  );

  // Second divide: sample by posterize step
  for (genvar j = StepsA + 1; j < NumCells + 1; j++) begin : g_div_b
    ppo_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (cell_vld[j]),
      .d_i    (cell_dat[j]),
      .vld_o  (cell_vld[j+1]),
      .q_o    (cell_dat[j+1])
    );
  end

  ppo_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (cell_vld[NumCells+1]),
    .d_i      (cell_dat[NumCells+1]),
    .vld_o    (out_valid_o),
    .sample_o (sample_out_o)
  );

`ifndef SYNTHESIS
  // Skid holds an item only after the chain was held
  a_skid_after_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> $past(!en))
    else $error("skid full without a preceding hold");

  // A held chain keeps its skid item
  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !en) |=> skid_vld_q)
    else $error("skid item lost while held");

  // A held chain keeps its valid bits at both ends
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(cell_vld[0]) && $stable(cell_vld[NumCells+1])))
    else $error("chain moved while held");
`endif

endmodule
`default_nettype wire
